// ===== sv/bbd_pkg.sv =====
// Shared types and constants for the banked bus decoder.
// Used by every module of the block; depends on nothing.
package bbd_pkg;

  // Widest word index any memory can need: 24-bit byte space, 32-bit words.
  localparam int unsigned IDX_W = 22;

  // Config port: byte address width and register indexes.
  localparam int unsigned CFG_AW        = 3;
  localparam logic        REG_WRAM_MODE = 1'b0;

  localparam logic [7:0] REGION_MAIN = 8'h02;
  localparam logic [7:0] REGION_WRAM = 8'h03;
  localparam logic [7:0] REGION_IO   = 8'h04;

  // Address bit that selects the always-private upper half of region 3.
  localparam int unsigned HIGH_WRAM_BIT = 23;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [1:0] WMODE_PRIVATE = 2'd0;
  localparam logic [1:0] WMODE_FIRST   = 2'd1;
  localparam logic [1:0] WMODE_SECOND  = 2'd2;
  localparam logic [1:0] WMODE_FULL    = 2'd3;

  typedef enum logic [2:0] {
    TGT_MAIN   = 3'd0,
    TGT_PRIV   = 3'd1,
    TGT_SHARED = 3'd2,
    TGT_IO     = 3'd3,
    TGT_NONE   = 3'd4
  } target_t;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  access_size;
    logic [31:0] address;
    logic [31:0] write_data;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  target;
    logic        io_forward;
  } out_t;

  // Classified access handed from front to back.
  typedef struct packed {
    target_t          target;
    logic             io_fwd;
    logic             is_write;
    logic [1:0]       size;
    logic [1:0]       lane;
    logic [3:0]       be;
    logic [31:0]      wdata;
    logic [IDX_W-1:0] idx;
  } dec_t;

endpackage

// ===== sv/bbd_front.sv =====
// Front end: config register, input handshake and address classification.
// Depends on bbd_pkg.
module bbd_front #(
  parameter int MAIN_ADDR_BITS    = 22,
  parameter int PRIVATE_ADDR_BITS = 16,
  parameter int SHARED_ADDR_BITS  = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bbd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bbd_pkg::in_t                in_data,
  input  logic                        q_full,
  output logic                        push,
  output bbd_pkg::dec_t               push_data
);

  localparam int unsigned IW = bbd_pkg::IDX_W;

  logic [1:0] wram_mode_r;
  logic       cfg_sel;
  logic [7:0] region;
  logic [31:0] addr;
  bbd_pkg::dec_t d;

  assign cfg_sel    = (cfg_paddr[bbd_pkg::CFG_AW-1:2] == bbd_pkg::REG_WRAM_MODE);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_sel ? {30'd0, wram_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wram_mode_r <= bbd_pkg::WMODE_PRIVATE;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel) begin
      wram_mode_r <= cfg_pwdata[1:0];
    end
  end

  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;
  assign push_data = d;

  assign addr   = in_data.address;
  assign region = addr[31:24];

  always_comb begin
    d          = '0;
    d.is_write = in_data.req_type;
    d.target   = bbd_pkg::TGT_NONE;
    // Align down to the size; narrow data is replicated across lanes.
    unique case (in_data.access_size)
      bbd_pkg::SIZE_BYTE: begin
        d.size  = bbd_pkg::SIZE_BYTE;
        d.lane  = addr[1:0];
        d.be    = 4'b0001 << addr[1:0];
        d.wdata = {4{in_data.write_data[7:0]}};
      end
      bbd_pkg::SIZE_HALF: begin
        d.size  = bbd_pkg::SIZE_HALF;
        d.lane  = {addr[1], 1'b0};
        d.be    = addr[1] ? 4'b1100 : 4'b0011;
        d.wdata = {2{in_data.write_data[15:0]}};
      end
      default: begin
        // size code three acts as a word
        d.size  = bbd_pkg::SIZE_WORD;
        d.lane  = 2'd0;
        d.be    = 4'b1111;
        d.wdata = in_data.write_data;
      end
    endcase

    unique case (region)
      bbd_pkg::REGION_MAIN: begin
        d.target = bbd_pkg::TGT_MAIN;
        d.idx    = IW'(addr[MAIN_ADDR_BITS-1:2]);
      end
      bbd_pkg::REGION_WRAM: begin
        if (addr[bbd_pkg::HIGH_WRAM_BIT] || wram_mode_r == bbd_pkg::WMODE_PRIVATE) begin
          d.target = bbd_pkg::TGT_PRIV;
          d.idx    = IW'(addr[PRIVATE_ADDR_BITS-1:2]);
        end else begin
          d.target = bbd_pkg::TGT_SHARED;
          unique case (wram_mode_r)
            bbd_pkg::WMODE_FIRST:  d.idx = IW'({1'b0, addr[SHARED_ADDR_BITS-2:2]});
            bbd_pkg::WMODE_SECOND: d.idx = IW'({1'b1, addr[SHARED_ADDR_BITS-2:2]});
            default:               d.idx = IW'(addr[SHARED_ADDR_BITS-1:2]);
          endcase
        end
      end
      bbd_pkg::REGION_IO: begin
        d.target = bbd_pkg::TGT_IO;
        d.io_fwd = 1'b1;
      end
      default: begin
        d.target = bbd_pkg::TGT_NONE;
      end
    endcase
  end

endmodule

// ===== sv/bbd_queue.sv =====
// Two-entry queue of classified accesses between front and back.
// Depends on bbd_pkg.
module bbd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bbd_pkg::dec_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output bbd_pkg::dec_t head_data
);

  bbd_pkg::dec_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/bbd_back.sv =====
// Back end: the three RAMs, read lane extraction and the output register.
// Depends on bbd_pkg.
module bbd_back #(
  parameter int MAIN_ADDR_BITS    = 22,
  parameter int PRIVATE_ADDR_BITS = 16,
  parameter int SHARED_ADDR_BITS  = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  bbd_pkg::dec_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output bbd_pkg::out_t out_data
);

  localparam int MAIN_IW   = MAIN_ADDR_BITS - 2;
  localparam int PRIV_IW   = PRIVATE_ADDR_BITS - 2;
  localparam int SHARED_IW = SHARED_ADDR_BITS - 2;

  logic [31:0] main_mem   [2**MAIN_IW];
  logic [31:0] priv_mem   [2**PRIV_IW];
  logic [31:0] shared_mem [2**SHARED_IW];

  logic [MAIN_IW-1:0]   main_idx;
  logic [PRIV_IW-1:0]   priv_idx;
  logic [SHARED_IW-1:0] shared_idx;

  logic [31:0] main_rd_r, priv_rd_r, shared_rd_r;

  logic          pend_r, pend_nxt;
  bbd_pkg::dec_t pend_d_r;
  logic          out_valid_r, out_valid_nxt;
  bbd_pkg::out_t out_data_r;

  logic        issue, pend_adv;
  logic [31:0] word, shifted, lane_mask, rdata;

  assign main_idx   = q_data.idx[MAIN_IW-1:0];
  assign priv_idx   = q_data.idx[PRIV_IW-1:0];
  assign shared_idx = q_data.idx[SHARED_IW-1:0];

  // The pending stage moves on when the output register is free or draining.
  assign pend_adv = pend_r && (!out_valid_r || !out_stall);
  assign issue    = q_valid && (!pend_r || pend_adv);
  assign q_pop    = issue;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (issue && q_data.target == bbd_pkg::TGT_MAIN) begin
      if (q_data.is_write) begin
        for (int b = 0; b < 4; b++) begin
          if (q_data.be[b]) main_mem[main_idx][8*b +: 8] <= q_data.wdata[8*b +: 8];
        end
      end
      main_rd_r <= main_mem[main_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (issue && q_data.target == bbd_pkg::TGT_PRIV) begin
      if (q_data.is_write) begin
        for (int b = 0; b < 4; b++) begin
          if (q_data.be[b]) priv_mem[priv_idx][8*b +: 8] <= q_data.wdata[8*b +: 8];
        end
      end
      priv_rd_r <= priv_mem[priv_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (issue && q_data.target == bbd_pkg::TGT_SHARED) begin
      if (q_data.is_write) begin
        for (int b = 0; b < 4; b++) begin
          if (q_data.be[b]) shared_mem[shared_idx][8*b +: 8] <= q_data.wdata[8*b +: 8];
        end
      end
      shared_rd_r <= shared_mem[shared_idx];
    end
  end

  always_comb begin
    case (pend_d_r.target)
      bbd_pkg::TGT_MAIN:   word = main_rd_r;
      bbd_pkg::TGT_PRIV:   word = priv_rd_r;
      bbd_pkg::TGT_SHARED: word = shared_rd_r;
      default:             word = 32'd0;
    endcase
    shifted = word >> {pend_d_r.lane, 3'b000};
    case (pend_d_r.size)
      bbd_pkg::SIZE_BYTE: lane_mask = 32'h0000_00FF;
      bbd_pkg::SIZE_HALF: lane_mask = 32'h0000_FFFF;
      default:            lane_mask = 32'hFFFF_FFFF;
    endcase
    rdata = pend_d_r.is_write ? 32'd0 : (shifted & lane_mask);
  end

  always_comb begin
    pend_nxt = issue ? 1'b1 : (pend_adv ? 1'b0 : pend_r);
    if (pend_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_d_r <= q_data;
    end
    if (pend_adv) begin
      out_data_r.read_data  <= rdata;
      out_data_r.target     <= pend_d_r.target;
      out_data_r.io_forward <= pend_d_r.io_fwd;
    end
  end

endmodule

// ===== sv/banked_bus_decoder_with_wram_split.sv =====
// Top level of the banked bus decoder with split shared work RAM.
// Depends on bbd_pkg, bbd_front, bbd_queue and bbd_back.
//
// Usage: one bus access per input transfer (in_data: read/write, size,
// address, write data). Each access yields exactly one result transfer
// (out_data: read data, target, I/O forward flag), in order.
// Address bits 31:24 pick main RAM, private or shared WRAM, the I/O port
// or nothing; wram_mode (APB register 0) sets the low WRAM region slice.
// Each access passes the queue, the pending stage (RAM read) and the
// output register. Throughput: one access per cycle while out_stall is
// low, set by the single port of each RAM (one read or write per cycle).
// A two-entry queue separates the classifying front from the RAM back end.
// When the receiver stalls, the output register holds, the pending stage
// and queue fill, and in_stall rises once the queue is full.
// Reset clears wram_mode to 0 and empties the pipeline; RAM contents are
// not cleared, so a location must be written before it is read.
module banked_bus_decoder_with_wram_split #(
  parameter int MAIN_ADDR_BITS    = 22,
  parameter int PRIVATE_ADDR_BITS = 16,
  parameter int SHARED_ADDR_BITS  = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bbd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bbd_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bbd_pkg::out_t               out_data
);

  logic          q_full, push, q_valid, q_pop;
  bbd_pkg::dec_t push_data, q_data;

  bbd_front #(
    .MAIN_ADDR_BITS   (MAIN_ADDR_BITS),
    .PRIVATE_ADDR_BITS(PRIVATE_ADDR_BITS),
    .SHARED_ADDR_BITS (SHARED_ADDR_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  bbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_data (q_data)
  );

  bbd_back #(
    .MAIN_ADDR_BITS   (MAIN_ADDR_BITS),
    .PRIVATE_ADDR_BITS(PRIVATE_ADDR_BITS),
    .SHARED_ADDR_BITS (SHARED_ADDR_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ===== sim/bbd_access_checker.sv =====
// Scoreboard for the banked bus decoder: watches the config port and both channels,
// predicts each access result and compares it with what the block returns.
// Depends on bbd_pkg for payload types, region codes and register indexes.
module bbd_access_checker
  import bbd_pkg::*;
#(
  parameter int MAIN_ADDR_BITS    = 22,
  parameter int PRIVATE_ADDR_BITS = 16,
  parameter int SHARED_ADDR_BITS  = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic [31:0]       cfg_prdata,
  input  logic              cfg_pready,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_t               in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_t              out_data,
  output int                pending,
  output int                errors
);

  localparam logic [31:0] MAIN_MASK   = (32'd1 << MAIN_ADDR_BITS) - 32'd1;
  localparam logic [31:0] PRIV_MASK   = (32'd1 << PRIVATE_ADDR_BITS) - 32'd1;
  localparam logic [31:0] SHARED_MASK = (32'd1 << SHARED_ADDR_BITS) - 32'd1;
  localparam logic [31:0] SHARED_HALF = 32'd1 << (SHARED_ADDR_BITS - 1);

  out_t        expected_results[$];
  logic [31:0] ram_words[longint];
  logic [1:0]  wram_mode;
  out_t        want;

  initial errors = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
    errors++;
  endtask

  // One read or write of a byte, halfword or word inside a bank (offset pre-masked).
  function automatic logic [31:0] ram_access(input target_t bank, input logic [31:0] off,
                                             input logic [1:0] sz, input logic wr,
                                             input logic [31:0] wdata);
    logic [31:0] lanes;
    logic [31:0] word;
    int          shift;
    longint      key;
    case (sz)
      SIZE_BYTE: lanes = 32'h0000_00FF;
      SIZE_HALF: begin
        lanes  = 32'h0000_FFFF;
        off[0] = 1'b0;
      end
      default: begin
        lanes     = 32'hFFFF_FFFF;
        off[1:0]  = 2'b00;
      end
    endcase
    shift = off[1:0] * 8;
    key   = (longint'(bank) << 32) | longint'(off >> 2);
    word  = ram_words.exists(key) ? ram_words[key] : 32'd0;
    if (wr) begin
      ram_words[key] = (word & ~(lanes << shift)) | ((wdata & lanes) << shift);
      return 32'd0;
    end
    return (word >> shift) & lanes;
  endfunction

  function automatic out_t predict_access(input in_t acc);
    out_t        res;
    logic [31:0] a;
    logic [31:0] off;
    logic [1:0]  sz;
    target_t     bank;
    a    = acc.address;
    // size code three behaves as a word
    sz   = (acc.access_size > SIZE_WORD) ? SIZE_WORD : acc.access_size;
    res  = '0;
    off  = '0;
    bank = TGT_NONE;
    case (a[31:24])
      REGION_MAIN: begin
        bank = TGT_MAIN;
        off  = a & MAIN_MASK;
      end
      REGION_WRAM: begin
        if (a[HIGH_WRAM_BIT] || wram_mode == WMODE_PRIVATE) begin
          bank = TGT_PRIV;
          off  = a & PRIV_MASK;
        end else begin
          bank = TGT_SHARED;
          case (wram_mode)
            WMODE_FIRST:  off = a & (SHARED_HALF - 32'd1);
            WMODE_SECOND: off = SHARED_HALF | (a & (SHARED_HALF - 32'd1));
            default:      off = a & SHARED_MASK;
          endcase
        end
      end
      REGION_IO: begin
        bank           = TGT_IO;
        res.io_forward = 1'b1;
      end
      default: ;
    endcase
    res.target = bank;
    if (bank == TGT_MAIN || bank == TGT_PRIV || bank == TGT_SHARED)
      res.read_data = ram_access(bank, off, sz, acc.req_type, acc.write_data);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      wram_mode = WMODE_PRIVATE;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready &&
          cfg_paddr[CFG_AW-1:2] == REG_WRAM_MODE) begin
        if (cfg_pwrite)
          wram_mode = cfg_pwdata[1:0];
        else if (cfg_prdata !== {30'd0, wram_mode})
          report_mismatch("wram_mode readback", cfg_prdata, {30'd0, wram_mode});
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no access outstanding", out_data.read_data, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_data !== want.read_data)
            report_mismatch("read_data", out_data.read_data, want.read_data);
          if (out_data.target !== want.target)
            report_mismatch("target", 32'(out_data.target), 32'(want.target));
          if (out_data.io_forward !== want.io_forward)
            report_mismatch("io_forward", 32'(out_data.io_forward), 32'(want.io_forward));
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_access(in_data));
      pending <= expected_results.size();
    end
  end

endmodule

// ===== sim/banked_bus_decoder_with_wram_split_tb.sv =====
// Testbench top for the banked bus decoder: clock, reset, config writes, access
// stimulus and receiver stalls; results are judged by bbd_access_checker.
// Depends on bbd_pkg, banked_bus_decoder_with_wram_split and bbd_access_checker.
module banked_bus_decoder_with_wram_split_tb;
  import bbd_pkg::*;

  localparam int MAIN_ADDR_BITS    = 22;
  localparam int PRIVATE_ADDR_BITS = 16;
  localparam int SHARED_ADDR_BITS  = 15;

  localparam logic        REQ_READ   = 1'b0;
  localparam logic        REQ_WRITE  = 1'b1;
  localparam logic [1:0]  SIZE_CODE3 = 2'd3;

  localparam logic [CFG_AW-1:0] WRAM_MODE_ADDR  = {REG_WRAM_MODE, 2'b00};
  localparam logic [CFG_AW-1:0] UNUSED_REG_ADDR = {~REG_WRAM_MODE, 2'b00};

  localparam logic [31:0] MAIN_MASK   = (32'd1 << MAIN_ADDR_BITS) - 32'd1;
  localparam logic [31:0] PRIV_MASK   = (32'd1 << PRIVATE_ADDR_BITS) - 32'd1;
  localparam logic [31:0] SHARED_MASK = (32'd1 << SHARED_ADDR_BITS) - 32'd1;
  localparam logic [31:0] SHARED_HALF = 32'd1 << (SHARED_ADDR_BITS - 1);

  localparam int PHASE_ITEMS = 135;
  localparam int POOL_DEPTH  = 128;
  localparam int HOLD_AT     = 330;
  localparam int HOLD_CYCLES = 120;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  int                pending;
  int                errors;

  logic [1:0]  cur_mode;
  bit          written_bytes[longint];
  logic [31:0] write_pool[$];
  int unsigned accesses_sent;
  int          burst_left;
  bit          hold_done;
  logic [1:0]  mode_plan [0:6] = '{WMODE_FULL, WMODE_FIRST, WMODE_SECOND, WMODE_PRIVATE,
                                   WMODE_SECOND, WMODE_FULL, WMODE_FIRST};

  banked_bus_decoder_with_wram_split #(
    .MAIN_ADDR_BITS   (MAIN_ADDR_BITS),
    .PRIVATE_ADDR_BITS(PRIVATE_ADDR_BITS),
    .SHARED_ADDR_BITS (SHARED_ADDR_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  bbd_access_checker #(
    .MAIN_ADDR_BITS   (MAIN_ADDR_BITS),
    .PRIVATE_ADDR_BITS(PRIVATE_ADDR_BITS),
    .SHARED_ADDR_BITS (SHARED_ADDR_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .pending    (pending),
    .errors     (errors)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Physical bytes touched by an access under the current mode; 0 when no RAM is hit.
  function automatic bit locate(input logic [31:0] a, input logic [1:0] sz,
                                output longint base, output int n);
    logic [31:0] off;
    target_t     bank;
    n    = (sz == SIZE_BYTE) ? 1 : (sz == SIZE_HALF) ? 2 : 4;
    base = 0;
    if (a[31:24] == REGION_MAIN) begin
      bank = TGT_MAIN;
      off  = a & MAIN_MASK;
    end else if (a[31:24] == REGION_WRAM && (a[HIGH_WRAM_BIT] || cur_mode == WMODE_PRIVATE)) begin
      bank = TGT_PRIV;
      off  = a & PRIV_MASK;
    end else if (a[31:24] == REGION_WRAM) begin
      bank = TGT_SHARED;
      case (cur_mode)
        WMODE_FIRST:  off = a & (SHARED_HALF - 32'd1);
        WMODE_SECOND: off = SHARED_HALF | (a & (SHARED_HALF - 32'd1));
        default:      off = a & SHARED_MASK;
      endcase
    end else begin
      return 1'b0;
    end
    off  = off & ~(n - 1);
    base = (longint'(bank) << 32) | longint'(off);
    return 1'b1;
  endfunction

  // RAM contents are undefined until written, so only read bytes that were stored.
  function automatic bit read_ok(input logic [31:0] a, input logic [1:0] sz);
    longint base;
    int     n;
    if (!locate(a, sz, base, n))
      return 1'b1;
    for (int i = 0; i < n; i++)
      if (!written_bytes.exists(base + i))
        return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_item(input in_t acc);
    longint base;
    int     n;
    int     r;
    int     gap;
    if (acc.req_type == REQ_WRITE && locate(acc.address, acc.access_size, base, n)) begin
      for (int i = 0; i < n; i++)
        written_bytes[base + i] = 1'b1;
      write_pool.push_back(acc.address);
      if (write_pool.size() > POOL_DEPTH)
        void'(write_pool.pop_front());
    end
    in_valid <= 1'b1;
    in_data  <= acc;
    do @(posedge clk); while (in_stall);
    accesses_sent++;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if (r < 4) begin
      burst_left = $urandom_range(20, 40);
      gap = 0;
    end else begin
      gap = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) :
            (r < 98) ? $urandom_range(4, 12) : $urandom_range(20, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic bus_access(input logic rw, input logic [1:0] sz, input logic [31:0] a,
                            input logic [31:0] d);
    in_t acc;
    acc.req_type    = rw;
    acc.access_size = sz;
    acc.address     = a;
    acc.write_data  = d;
    send_item(acc);
  endtask

  function automatic logic [31:0] pick_mapped_addr();
    logic [31:0] a;
    logic        fill;
    a    = $urandom;
    fill = 1'($urandom);
    case ($urandom_range(0, 2))
      0: a[31:24] = REGION_MAIN;
      1: begin
        a[31:24]          = REGION_WRAM;
        a[HIGH_WRAM_BIT]  = 1'b1;
      end
      default: begin
        a[31:24]          = REGION_WRAM;
        a[HIGH_WRAM_BIT]  = 1'b0;
      end
    endcase
    // most writes land near the bottom or top of a bank so reads find data
    if ($urandom_range(0, 9) < 7)
      a[MAIN_ADDR_BITS-1:6] = {(MAIN_ADDR_BITS - 6){fill}};
    return a;
  endfunction

  task automatic make_access(output in_t acc);
    int          r;
    int          pick;
    logic [31:0] a;
    logic [7:0]  region;
    r = $urandom_range(0, 99);
    acc.req_type    = 1'($urandom);
    acc.access_size = 2'($urandom);
    acc.address     = $urandom;
    acc.write_data  = $urandom;
    if (r < 40) begin
      acc.req_type = REQ_WRITE;
      acc.address  = pick_mapped_addr();
    end else if (r < 78 && write_pool.size() > 0) begin
      pick = $urandom_range(0, write_pool.size() - 1);
      a    = write_pool[pick];
      // move through a mirror of the same location
      if (a[31:24] == REGION_MAIN) begin
        a[23:22] = 2'($urandom);
      end else begin
        a[22:16] = 7'($urandom);
        if (cur_mode == WMODE_PRIVATE)
          a[HIGH_WRAM_BIT] = 1'($urandom);
      end
      acc.req_type = REQ_READ;
      acc.address  = a;
      if (!read_ok(a, acc.access_size)) begin
        acc.address     = write_pool[pick];
        acc.access_size = SIZE_BYTE;
      end
    end else if (r < 86) begin
      acc.address[31:24] = REGION_IO;
    end else if (r < 95) begin
      do region = 8'($urandom);
      while (region == REGION_MAIN || region == REGION_WRAM || region == REGION_IO);
      acc.address[31:24] = region;
    end
    if (acc.req_type == REQ_READ && !read_ok(acc.address, acc.access_size))
      acc.req_type = REQ_WRITE;
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read(input logic [CFG_AW-1:0] addr);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] mode);
    drain();
    // index past the register list: must be ignored
    cfg_write(UNUSED_REG_ADDR, $urandom);
    cfg_write(WRAM_MODE_ADDR, {30'($urandom), mode});
    cur_mode = mode;
    cfg_read(WRAM_MODE_ADDR);
  endtask

  // Receiver: random stall segments, plus one long hold-off to back the block up.
  initial begin
    int seg;
    int pct;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && accesses_sent >= HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        seg = $urandom_range(4, 40);
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 20;
          2:       pct = 50;
          default: pct = ($urandom_range(0, 3) == 0) ? 95 : 35;
        endcase
        repeat (seg) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("banked_bus_decoder_with_wram_split regression: fail");
    $finish;
  end

  initial begin
    in_t acc;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    cur_mode      = WMODE_PRIVATE;
    accesses_sent = 0;
    burst_left    = 0;
    hold_done     = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    cfg_read(WRAM_MODE_ADDR);

    // directed: bank edges, mirrors, odd alignment, size code three, I/O, unmapped
    bus_access(REQ_WRITE, SIZE_WORD,  32'h0200_0000, 32'hFFFF_FFFF);
    bus_access(REQ_READ,  SIZE_WORD,  32'h0200_0000, 32'h0000_0000);
    bus_access(REQ_WRITE, SIZE_BYTE,  32'h02C0_0003, 32'h0000_00A5);
    bus_access(REQ_READ,  SIZE_HALF,  32'h0240_0003, 32'hFFFF_FFFF);
    bus_access(REQ_WRITE, SIZE_CODE3, 32'h023F_FFFF, 32'h1234_5678);
    bus_access(REQ_READ,  SIZE_CODE3, 32'h02FF_FFFE, 32'h0000_0000);
    bus_access(REQ_WRITE, SIZE_WORD,  32'h03FF_FFFF, 32'hDEAD_BEEF);
    bus_access(REQ_WRITE, SIZE_HALF,  32'h0380_FFFF, 32'hFFFF_5A5A);
    bus_access(REQ_READ,  SIZE_WORD,  32'h0300_FFFD, 32'h0000_0000);
    bus_access(REQ_READ,  SIZE_BYTE,  32'h037F_FFFF, 32'h0000_0000);
    bus_access(REQ_WRITE, SIZE_WORD,  32'h0400_0010, 32'h0BAD_F00D);
    bus_access(REQ_READ,  SIZE_HALF,  32'h04FF_FFFF, 32'h0000_0000);
    bus_access(REQ_WRITE, SIZE_WORD,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    bus_access(REQ_READ,  SIZE_WORD,  32'h0000_0000, 32'h0000_0000);
    bus_access(REQ_READ,  SIZE_BYTE,  32'h0500_0000, 32'h0000_0000);
    bus_access(REQ_WRITE, SIZE_HALF,  32'h0100_0000, 32'h0000_0000);
    bus_access(REQ_WRITE, SIZE_BYTE,  32'h0200_0001, 32'h0000_0000);
    bus_access(REQ_READ,  SIZE_WORD,  32'h0200_0000, 32'h0000_0000);
    bus_access(REQ_WRITE, SIZE_HALF,  32'h0200_0000, 32'hFFFF_0000);
    bus_access(REQ_READ,  SIZE_WORD,  32'h0200_0002, 32'h0000_0000);

    foreach (mode_plan[p]) begin
      set_mode(mode_plan[p]);
      repeat (PHASE_ITEMS) begin
        make_access(acc);
        send_item(acc);
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (errors == 0)
      $display("banked_bus_decoder_with_wram_split regression: pass");
    else
      $display("banked_bus_decoder_with_wram_split regression: fail");
    $finish;
  end

endmodule
